/* src/aqkr_pkg.sv */
// shared types and constants for the aging queue with keyed removal
`default_nettype none
package aqkr_pkg;

  localparam int QueueDepth = 64;
  localparam int IdxW       = $clog2(QueueDepth);
  localparam int CntW       = $clog2(QueueDepth + 1);
  localparam int MaxEntW    = 7;
  localparam int HopW       = 32;
  localparam int PayW       = 16;
  localparam int TimeW      = 32;
  localparam int ModeW      = 3;
  localparam int CfgIdxW    = 1;
  localparam int CfgDataW   = 32;

  // register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] CFG_MAX_ENTRIES = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAX_DELAY   = 1'd1;

  localparam logic [MaxEntW-1:0] MAX_ENTRIES_RST = 7'd64;
  localparam logic [TimeW-1:0]   MAX_DELAY_RST   = 32'd30000;

  typedef enum logic [ModeW-1:0] {
    MODE_ENQ   = 3'd0,
    MODE_DEQ   = 3'd1,
    MODE_TAKE  = 3'd2,
    MODE_FIND  = 3'd3,
    MODE_FLUSH = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic latch;
    logic scan_en;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_scan;
    logic scan_done;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

/* src/aqkr_ctrl.sv */
// controller state machine: accept, scan, deliver
`default_nettype none
module aqkr_ctrl
  import aqkr_pkg::*;
(
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  in_valid_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = sts_i.is_scan ? ST_SCAN : ST_FINISH;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_en = 1'b1;
        if (sts_i.scan_done) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

/* src/aqkr_datapath.sv */
// datapath: entry memories, purge and match scan, result register
`default_nettype none
module aqkr_datapath
  import aqkr_pkg::*;
(
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  input  wire  [ModeW-1:0]    mode_i,
  input  wire  [HopW-1:0]     next_hop_i,
  input  wire  [PayW-1:0]     payload_handle_i,
  input  wire  [TimeW-1:0]    now_time_i,
  input  wire                 cfg_valid_i,
  input  wire  [CfgIdxW-1:0]  cfg_index_i,
  input  wire  [CfgDataW-1:0] cfg_data_i,
  input  wire                 out_stall_i,
  output logic                out_valid_o,
  output logic                success_o,
  output logic [PayW-1:0]     out_payload_o,
  output logic [HopW-1:0]     out_next_hop_o,
  output logic [TimeW-1:0]    out_stamp_o,
  output logic [CntW-1:0]     occupancy_o,
  output logic [CntW-1:0]     expired_count_o
);

  logic [HopW-1:0]  hop_mem   [QueueDepth];
  logic [PayW-1:0]  pay_mem   [QueueDepth];
  logic [TimeW-1:0] stamp_mem [QueueDepth];

  logic [MaxEntW-1:0] max_entries_q;
  logic [TimeW-1:0]   max_delay_q;
  logic [CntW-1:0]    count_q, count_d;
  logic [CntW-1:0]    rd_idx_q, keep_q, expired_q;
  logic               pend_q, found_q, out_valid_q;

  logic [ModeW-1:0]   mode_q;
  logic [HopW-1:0]    hop_q, rd_hop_q, cap_hop_q;
  logic [PayW-1:0]    pay_q, rd_pay_q, cap_pay_q;
  logic [TimeW-1:0]   now_q, rd_stamp_q, cap_stamp_q;

  logic [CntW-1:0]    limit;
  logic               can_enq, is_scan_mode, alive, hit, remove, issue;
  logic               wr_en, ok;
  logic [IdxW-1:0]    wr_addr;
  logic [HopW-1:0]    wr_hop;
  logic [PayW-1:0]    wr_pay;
  logic [TimeW-1:0]   wr_stamp;

  // scan modes of the item on the input and of the held item
  assign sts_o.is_scan = (mode_i == MODE_DEQ) || (mode_i == MODE_TAKE) ||
                         (mode_i == MODE_FIND);
  assign is_scan_mode  = (mode_q == MODE_DEQ) || (mode_q == MODE_TAKE) ||
                         (mode_q == MODE_FIND);

  // capacity check
  assign limit   = (CntW'(max_entries_q) > CntW'(QueueDepth)) ? CntW'(QueueDepth)
                                                              : CntW'(max_entries_q);
  assign can_enq = count_q < limit;

  // age test and match on the entry read last cycle
  assign alive  = ({1'b0, rd_stamp_q} + {1'b0, max_delay_q}) > {1'b0, now_q};
  assign hit    = alive && !found_q &&
                  ((mode_q == MODE_DEQ) || (rd_hop_q == hop_q));
  assign remove = hit && (mode_q != MODE_FIND);
  assign issue  = cmd_i.scan_en && (rd_idx_q < count_q);

  assign sts_o.scan_done = !pend_q && (rd_idx_q >= count_q);
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  // single write port: compaction during scan, append on enqueue
  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = keep_q[IdxW-1:0];
    wr_hop   = rd_hop_q;
    wr_pay   = rd_pay_q;
    wr_stamp = rd_stamp_q;
    if (cmd_i.scan_en && pend_q && alive && !remove) begin
      wr_en = 1'b1;
    end else if (cmd_i.out_load && (mode_q == MODE_ENQ) && can_enq) begin
      wr_en    = 1'b1;
      wr_addr  = count_q[IdxW-1:0];
      wr_hop   = hop_q;
      wr_pay   = pay_q;
      wr_stamp = now_q;
    end
  end

  // result flag and new occupancy
  always_comb begin
    ok      = 1'b0;
    count_d = count_q;
    case (mode_q)
      MODE_ENQ: begin
        ok = can_enq;
        if (can_enq) begin
          count_d = count_q + CntW'(1);
        end
      end
      MODE_DEQ, MODE_TAKE, MODE_FIND: begin
        ok      = found_q;
        count_d = keep_q;
      end
      MODE_FLUSH: begin
        ok      = 1'b1;
        count_d = '0;
      end
      default: ok = 1'b0;
    endcase
  end

  // entry memories
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      hop_mem[wr_addr]   <= wr_hop;
      pay_mem[wr_addr]   <= wr_pay;
      stamp_mem[wr_addr] <= wr_stamp;
    end
    if (issue) begin
      rd_hop_q   <= hop_mem[rd_idx_q[IdxW-1:0]];
      rd_pay_q   <= pay_mem[rd_idx_q[IdxW-1:0]];
      rd_stamp_q <= stamp_mem[rd_idx_q[IdxW-1:0]];
    end
  end

  // held request and captured entry
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      mode_q      <= mode_i;
      hop_q       <= next_hop_i;
      pay_q       <= payload_handle_i;
      now_q       <= now_time_i;
      cap_hop_q   <= '0;
      cap_pay_q   <= '0;
      cap_stamp_q <= '0;
    end else if (cmd_i.scan_en && pend_q && remove) begin
      cap_hop_q   <= rd_hop_q;
      cap_pay_q   <= rd_pay_q;
      cap_stamp_q <= rd_stamp_q;
    end
    if (cmd_i.out_load) begin
      success_o       <= ok;
      out_payload_o   <= cap_pay_q;
      out_next_hop_o  <= cap_hop_q;
      out_stamp_o     <= cap_stamp_q;
      occupancy_o     <= count_d;
      expired_count_o <= is_scan_mode ? expired_q : '0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_entries_q <= MAX_ENTRIES_RST;
      max_delay_q   <= MAX_DELAY_RST;
      count_q       <= '0;
      rd_idx_q      <= '0;
      keep_q        <= '0;
      expired_q     <= '0;
      pend_q        <= 1'b0;
      found_q       <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_MAX_ENTRIES: max_entries_q <= cfg_data_i[MaxEntW-1:0];
          CFG_MAX_DELAY:   max_delay_q   <= cfg_data_i[TimeW-1:0];
          default:         max_delay_q   <= max_delay_q;
        endcase
      end
      if (cmd_i.latch) begin
        rd_idx_q  <= '0;
        keep_q    <= '0;
        expired_q <= '0;
        pend_q    <= 1'b0;
        found_q   <= 1'b0;
      end else if (cmd_i.scan_en) begin
        pend_q <= issue;
        if (issue) begin
          rd_idx_q <= rd_idx_q + CntW'(1);
        end
        if (pend_q) begin
          if (!alive) begin
            expired_q <= expired_q + CntW'(1);
          end else if (!remove) begin
            keep_q <= keep_q + CntW'(1);
          end
          if (hit) begin
            found_q <= 1'b1;
          end
        end
      end
      if (cmd_i.out_load) begin
        count_q <= count_d;
      end
      out_valid_q <= cmd_i.out_load | (out_valid_q & out_stall_i);
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

/* src/aging_queue_with_key_removal_top.sv */
// top level of the aging queue with keyed removal
//
// Usage:
// - in channel (in_valid_i / in_stall_o) carries one request: mode, next hop,
//   payload handle and current time. out channel (out_valid_o / out_stall_i)
//   returns exactly one result per request.
// - configuration writes go through cfg_valid_i / cfg_ready_o with index 0 for
//   the entry limit and 1 for the maximum delay; ready is always high.
// - one request is processed at a time. enqueue, flush and unused modes go from
//   accept straight to the finish state, which loads the result once the output
//   register is free and returns to idle for the next request. dequeue, take and
//   find walk the stored entries once through the entry memory (one write port),
//   one entry a cycle, purging, matching and compacting in the same pass; the
//   finish state then loads the result the same way before the next request.
// - the result sits in an output register; while the receiver stalls it holds
//   and a finished request waits for it, so the input channel stalls too.
// - reset empties the queue, restores limit 64 and delay 30000, and drops any
//   pending result; the memory needs no clearing pass.
`default_nettype none
module aging_queue_with_key_removal_top
  import aqkr_pkg::*;
(
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  wire  [ModeW-1:0]    mode_i,
  input  wire  [HopW-1:0]     next_hop_i,
  input  wire  [PayW-1:0]     payload_handle_i,
  input  wire  [TimeW-1:0]    now_time_i,
  input  wire                 cfg_valid_i,
  output logic                cfg_ready_o,
  input  wire  [CfgIdxW-1:0]  cfg_index_i,
  input  wire  [CfgDataW-1:0] cfg_data_i,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output logic                success_o,
  output logic [PayW-1:0]     out_payload_o,
  output logic [HopW-1:0]     out_next_hop_o,
  output logic [TimeW-1:0]    out_stamp_o,
  output logic [CntW-1:0]     occupancy_o,
  output logic [CntW-1:0]     expired_count_o
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  // sequencing
  aqkr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // storage and result path
  aqkr_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .mode_i           (mode_i),
    .next_hop_i       (next_hop_i),
    .payload_handle_i (payload_handle_i),
    .now_time_i       (now_time_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .success_o        (success_o),
    .out_payload_o    (out_payload_o),
    .out_next_hop_o   (out_next_hop_o),
    .out_stamp_o      (out_stamp_o),
    .occupancy_o      (occupancy_o),
    .expired_count_o  (expired_count_o)
  );

endmodule
`default_nettype wire
